@@ hdl/iso_ep_pkg.sv @@
// ----------------------------------------------------------------------------
// iso_ep_pkg
// types, character codes and arithmetic constants shared by the timestamp
// to epoch converter
// ----------------------------------------------------------------------------
package iso_ep_pkg;

	// character codes
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Z     = 8'h5A;

	// string layout
	localparam logic [4:0] POS_SUFFIX = 5'd19;
	localparam logic [4:0] LEN_ZULU   = 5'd20;
	localparam logic [4:0] LEN_OFFSET = 5'd25;
	localparam logic [4:0] POS_SAT    = 5'd26;

	// arithmetic constants
	localparam logic [16:0] RECIP_100   = 17'd5243;   // floor(x/100) = (x*5243) >> 19
	localparam logic [16:0] DAYS_YEAR   = 17'd365;
	localparam logic [22:0] EPOCH_SHIFT = 23'd719468;
	localparam logic [16:0] SEC_DAY     = 17'd86400;
	localparam logic [16:0] SEC_HOUR    = 17'd3600;
	localparam logic [16:0] SEC_MIN     = 17'd60;

	// shared unit modes
	localparam logic [1:0] MAC_LOAD = 2'd0;
	localparam logic [1:0] MAC_ADD  = 2'd1;
	localparam logic [1:0] MAC_SUB  = 2'd2;
	localparam logic [1:0] MAC_QUOT = 2'd3;

	typedef struct packed {
		logic        en;
		logic [1:0]  mode;
		logic [22:0] a;
		logic [16:0] b;
	} mac_cmd_t;

	typedef struct packed {
		logic        ok;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [6:0]  off_hour;
		logic [6:0]  off_minute;
		logic        neg;
		logic        has_off;
	} ts_fields_t;

	// day of a march-based year on which a month starts
	function automatic logic [8:0] month_start(logic [6:0] month);
		logic [8:0] r;
		case (month)
			7'd1:    r = 9'd306;
			7'd2:    r = 9'd337;
			7'd3:    r = 9'd0;
			7'd4:    r = 9'd31;
			7'd5:    r = 9'd61;
			7'd6:    r = 9'd92;
			7'd7:    r = 9'd122;
			7'd8:    r = 9'd153;
			7'd9:    r = 9'd184;
			7'd10:   r = 9'd214;
			7'd11:   r = 9'd245;
			7'd12:   r = 9'd275;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/iso_ep_parser.sv @@
// ----------------------------------------------------------------------------
// iso_ep_parser
// character scanner: position counter, separator checks and digit fields
// ----------------------------------------------------------------------------
module iso_ep_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [7:0]             character,
	input  logic                   clear,
	output iso_ep_pkg::ts_fields_t fields
);

	localparam logic [13:0] YEAR_MIN = 14'd1970;
	localparam logic [13:0] YEAR_MAX = 14'd9999;

	logic [4:0]  pos_q;
	logic        fmt_ok_q;
	logic [13:0] year_q;
	logic [6:0]  month_q, day_q, hour_q, minute_q, second_q, oh_q, om_q;
	logic        neg_q, zulu_q;
	logic        is_digit;
	logic [3:0]  dval;
	logic        len_ok;

	function automatic logic [6:0] push7(logic [6:0] acc, logic [3:0] d);
		logic [9:0] t;
		t = 10'({acc, 3'b000}) + 10'({acc, 1'b0}) + 10'(d);
		return t[6:0];
	endfunction

	function automatic logic [13:0] push14(logic [13:0] acc, logic [3:0] d);
		logic [16:0] t;
		t = 17'({acc, 3'b000}) + 17'({acc, 1'b0}) + 17'(d);
		return t[13:0];
	endfunction

	assign is_digit = (character >= iso_ep_pkg::CH_0) && (character <= iso_ep_pkg::CH_9);
	assign dval     = character[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fmt_ok_q <= 1'b1;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			oh_q     <= '0;
			om_q     <= '0;
			neg_q    <= 1'b0;
			zulu_q   <= 1'b0;
		end else if (clear) begin
			pos_q    <= '0;
			fmt_ok_q <= 1'b1;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			oh_q     <= '0;
			om_q     <= '0;
			neg_q    <= 1'b0;
			zulu_q   <= 1'b0;
		end else if (take) begin
			if (pos_q != iso_ep_pkg::POS_SAT) begin
				pos_q <= pos_q + 5'd1;
			end
			case (pos_q)
				5'd0, 5'd1, 5'd2, 5'd3: begin
					if (is_digit) year_q <= push14(year_q, dval);
					else fmt_ok_q <= 1'b0;
				end
				5'd5, 5'd6: begin
					if (is_digit) month_q <= push7(month_q, dval);
					else fmt_ok_q <= 1'b0;
				end
				5'd8, 5'd9: begin
					if (is_digit) day_q <= push7(day_q, dval);
					else fmt_ok_q <= 1'b0;
				end
				5'd11, 5'd12: begin
					if (is_digit) hour_q <= push7(hour_q, dval);
					else fmt_ok_q <= 1'b0;
				end
				5'd14, 5'd15: begin
					if (is_digit) minute_q <= push7(minute_q, dval);
					else fmt_ok_q <= 1'b0;
				end
				5'd17, 5'd18: begin
					if (is_digit) second_q <= push7(second_q, dval);
					else fmt_ok_q <= 1'b0;
				end
				5'd20, 5'd21: begin
					if (is_digit) oh_q <= push7(oh_q, dval);
					else fmt_ok_q <= 1'b0;
				end
				5'd23, 5'd24: begin
					if (is_digit) om_q <= push7(om_q, dval);
					else fmt_ok_q <= 1'b0;
				end
				5'd4, 5'd7: begin
					if (character != iso_ep_pkg::CH_DASH) fmt_ok_q <= 1'b0;
				end
				5'd10: begin
					if (character != iso_ep_pkg::CH_T) fmt_ok_q <= 1'b0;
				end
				5'd13, 5'd16, 5'd22: begin
					if (character != iso_ep_pkg::CH_COLON) fmt_ok_q <= 1'b0;
				end
				iso_ep_pkg::POS_SUFFIX: begin
					if (character == iso_ep_pkg::CH_Z) zulu_q <= 1'b1;
					else if (character == iso_ep_pkg::CH_DASH) neg_q <= 1'b1;
					else if (character != iso_ep_pkg::CH_PLUS) fmt_ok_q <= 1'b0;
				end
				default: begin
					fmt_ok_q <= 1'b0;
				end
			endcase
		end
	end

	// length and suffix must agree
	assign len_ok = ((pos_q == iso_ep_pkg::LEN_ZULU) && zulu_q) ||
	                ((pos_q == iso_ep_pkg::LEN_OFFSET) && !zulu_q &&
	                 (oh_q <= 7'd23) && (om_q <= 7'd59));

	always_comb begin
		fields.ok         = fmt_ok_q && len_ok &&
		                    (year_q >= YEAR_MIN) && (year_q <= YEAR_MAX) &&
		                    (month_q >= 7'd1) && (month_q <= 7'd12) &&
		                    (day_q >= 7'd1) && (day_q <= 7'd31) &&
		                    (hour_q <= 7'd23) && (minute_q <= 7'd59) &&
		                    (second_q <= 7'd60);
		fields.year       = year_q;
		fields.month      = month_q;
		fields.day        = day_q;
		fields.hour       = hour_q;
		fields.minute     = minute_q;
		fields.second     = second_q;
		fields.off_hour   = oh_q;
		fields.off_minute = om_q;
		fields.neg        = neg_q;
		fields.has_off    = (pos_q == iso_ep_pkg::LEN_OFFSET);
	end

endmodule

@@ hdl/iso_ep_mac.sv @@
// ----------------------------------------------------------------------------
// iso_ep_mac
// shared multiply-accumulate unit with a small quotient register
// ----------------------------------------------------------------------------
module iso_ep_mac (
	input  logic                 clk,
	input  iso_ep_pkg::mac_cmd_t cmd,
	output logic signed [39:0]   acc,
	output logic [6:0]           quot
);

	logic [39:0]        prod;
	logic signed [39:0] acc_q;
	logic [6:0]         quot_q;

	assign prod = 40'(cmd.a) * 40'(cmd.b);

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			case (cmd.mode)
				iso_ep_pkg::MAC_LOAD: acc_q  <= $signed(prod);
				iso_ep_pkg::MAC_ADD:  acc_q  <= acc_q + $signed(prod);
				iso_ep_pkg::MAC_SUB:  acc_q  <= acc_q - $signed(prod);
				iso_ep_pkg::MAC_QUOT: quot_q <= prod[25:19];
				default:              acc_q  <= acc_q;
			endcase
		end
	end

	assign acc  = acc_q;
	assign quot = quot_q;

endmodule

@@ hdl/iso_ep_seq.sv @@
// ----------------------------------------------------------------------------
// iso_ep_seq
// step sequencer for the days-from-civil and seconds arithmetic
// ----------------------------------------------------------------------------
module iso_ep_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  iso_ep_pkg::ts_fields_t fields,
	input  logic signed [39:0]     acc,
	input  logic [6:0]             quot,
	output iso_ep_pkg::mac_cmd_t   cmd,
	output logic                   done,
	output logic                   res_ok
);

	localparam logic [3:0] STEP_QUOT   = 4'd0;
	localparam logic [3:0] STEP_YEARS  = 4'd1;
	localparam logic [3:0] STEP_LEAP4  = 4'd2;
	localparam logic [3:0] STEP_CENT   = 4'd3;
	localparam logic [3:0] STEP_LEAP4C = 4'd4;
	localparam logic [3:0] STEP_DOY    = 4'd5;
	localparam logic [3:0] STEP_EPOCH  = 4'd6;
	localparam logic [3:0] STEP_DAYSEC = 4'd7;
	localparam logic [3:0] STEP_HOUR   = 4'd8;
	localparam logic [3:0] STEP_MIN    = 4'd9;
	localparam logic [3:0] STEP_SEC    = 4'd10;
	localparam logic [3:0] STEP_OFFH   = 4'd11;
	localparam logic [3:0] STEP_OFFM   = 4'd12;

	iso_ep_pkg::ts_fields_t fld_q;
	logic        busy_q;
	logic [3:0]  step_q;
	logic        done_q;
	logic [13:0] yy;
	logic [22:0] doy_a;
	logic [1:0]  off_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_QUOT;
			end else if (busy_q) begin
				if (step_q == STEP_OFFM) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			fld_q <= fields;
		end
	end

	// years counted from march, so january and february belong to the year before
	assign yy       = fld_q.year - 14'(fld_q.month <= 7'd2);
	assign doy_a    = 23'(iso_ep_pkg::month_start(fld_q.month)) + 23'(fld_q.day) - 23'd1;
	assign off_mode = fld_q.neg ? iso_ep_pkg::MAC_ADD : iso_ep_pkg::MAC_SUB;

	always_comb begin
		cmd.en   = busy_q;
		cmd.mode = iso_ep_pkg::MAC_ADD;
		cmd.a    = '0;
		cmd.b    = 17'd1;
		case (step_q)
			STEP_QUOT: begin
				cmd.mode = iso_ep_pkg::MAC_QUOT;
				cmd.a    = 23'(yy);
				cmd.b    = iso_ep_pkg::RECIP_100;
			end
			STEP_YEARS: begin
				cmd.mode = iso_ep_pkg::MAC_LOAD;
				cmd.a    = 23'(yy);
				cmd.b    = iso_ep_pkg::DAYS_YEAR;
			end
			STEP_LEAP4: begin
				cmd.a = 23'(yy[13:2]);
			end
			STEP_CENT: begin
				cmd.mode = iso_ep_pkg::MAC_SUB;
				cmd.a    = 23'(quot);
			end
			STEP_LEAP4C: begin
				cmd.a = 23'(quot[6:2]);
			end
			STEP_DOY: begin
				cmd.a = doy_a;
			end
			STEP_EPOCH: begin
				cmd.mode = iso_ep_pkg::MAC_SUB;
				cmd.a    = iso_ep_pkg::EPOCH_SHIFT;
			end
			STEP_DAYSEC: begin
				cmd.mode = iso_ep_pkg::MAC_LOAD;
				cmd.a    = acc[22:0];
				cmd.b    = iso_ep_pkg::SEC_DAY;
			end
			STEP_HOUR: begin
				cmd.a = 23'(fld_q.hour);
				cmd.b = iso_ep_pkg::SEC_HOUR;
			end
			STEP_MIN: begin
				cmd.a = 23'(fld_q.minute);
				cmd.b = iso_ep_pkg::SEC_MIN;
			end
			STEP_SEC: begin
				cmd.a = 23'(fld_q.second);
			end
			STEP_OFFH: begin
				cmd.mode = off_mode;
				cmd.a    = 23'(fld_q.off_hour);
				cmd.b    = fld_q.has_off ? iso_ep_pkg::SEC_HOUR : 17'd0;
			end
			STEP_OFFM: begin
				cmd.mode = off_mode;
				cmd.a    = 23'(fld_q.off_minute);
				cmd.b    = fld_q.has_off ? iso_ep_pkg::SEC_MIN : 17'd0;
			end
			default: begin
				cmd.en = 1'b0;
			end
		endcase
	end

	assign done   = done_q;
	assign res_ok = fld_q.ok;

endmodule

@@ hdl/iso8601_timestamp_to_epoch_unit.sv @@
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch_unit
// ISO 8601 timestamp text to Unix seconds converter
// ----------------------------------------------------------------------------
// The block takes a timestamp one character per transaction on the item
// channel, last_char marking the final byte, in the form YYYY-MM-DDTHH:MM:SS
// followed by Z or a +HH:MM / -HH:MM offset. Any character but the last
// leaves item_ready high. The last one starts a 13-step run of a single
// shared multiply-accumulate unit (days from civil, then seconds and
// offset), and the result is then loaded into the output register and
// offered as the result transaction. item_ready stays low until that load,
// which waits while the output register still holds an uncollected result.
// The next timestamp's characters are taken while the loaded result waits
// to be collected.
// A rejected string gives valid_res 0 with epoch_seconds 0.
// ----------------------------------------------------------------------------
module iso8601_timestamp_to_epoch_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [7:0]         character,
	input  logic               last_char,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [38:0] epoch_seconds,
	output logic               valid_res
);

	localparam logic [1:0] ST_PARSE = 2'd0;
	localparam logic [1:0] ST_CALC  = 2'd1;
	localparam logic [1:0] ST_HOLD  = 2'd2;

	logic [1:0]  state_q;
	logic        start_q;
	logic        out_valid_q;
	logic [38:0] epoch_q;
	logic        vres_q;

	logic                   item_accept;
	logic                   out_free;
	logic                   load_out;
	logic                   calc_done;
	logic                   calc_ok;
	logic signed [39:0]     acc;
	logic [6:0]             quot;
	iso_ep_pkg::ts_fields_t fields;
	iso_ep_pkg::mac_cmd_t   cmd;

	// characters only flow while no conversion is in flight
	assign item_ready  = (state_q == ST_PARSE);
	assign item_accept = item_valid && item_ready;
	assign out_free    = !out_valid_q || result_ready;
	assign load_out    = out_free && (((state_q == ST_CALC) && calc_done) ||
	                                  (state_q == ST_HOLD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_PARSE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= item_accept && last_char;
			case (state_q)
				ST_PARSE: begin
					if (item_accept && last_char) state_q <= ST_CALC;
				end
				ST_CALC: begin
					// a finished result waits in ST_HOLD if the output is still occupied
					if (calc_done) state_q <= load_out ? ST_PARSE : ST_HOLD;
				end
				ST_HOLD: begin
					if (load_out) state_q <= ST_PARSE;
				end
				default: begin
					state_q <= ST_PARSE;
				end
			endcase
			if (load_out) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	// result payload, zero on reject
	always_ff @(posedge clk) begin
		if (load_out) begin
			epoch_q <= calc_ok ? acc[38:0] : 39'd0;
			vres_q  <= calc_ok;
		end
	end

	iso_ep_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (item_accept),
		.character (character),
		.clear     (start_q),
		.fields    (fields)
	);

	iso_ep_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.fields (fields),
		.acc    (acc),
		.quot   (quot),
		.cmd    (cmd),
		.done   (calc_done),
		.res_ok (calc_ok)
	);

	iso_ep_mac u_mac (
		.clk  (clk),
		.cmd  (cmd),
		.acc  (acc),
		.quot (quot)
	);

	assign result_valid  = out_valid_q;
	assign epoch_seconds = $signed(epoch_q);
	assign valid_res     = vres_q;

endmodule

@@ hdl/iso_ep_chk.sv @@
// ----------------------------------------------------------------------------
// iso_ep_chk
// port-level checks for the timestamp to epoch converter
// ----------------------------------------------------------------------------
module iso_ep_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_ready,
	input logic [7:0]         character,
	input logic               last_char,
	input logic               result_valid,
	input logic               result_ready,
	input logic signed [38:0] epoch_seconds,
	input logic               valid_res
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(epoch_seconds) &&
		$stable(valid_res))
		else $error("result changed while stalled");

	// rejected strings report zero
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !valid_res |-> epoch_seconds == 39'sd0)
		else $error("rejected result not zero");

	// the converter is busy right after the final character
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && last_char |=> !item_ready)
		else $error("character accepted during conversion");

	// accepted timestamps stay inside the representable span
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && valid_res |->
		epoch_seconds >= -39'sd86340 && epoch_seconds <= 39'sd253402387140)
		else $error("epoch out of range");

endmodule

bind iso8601_timestamp_to_epoch_unit iso_ep_chk u_iso_ep_chk (.*);

@@ tb/iso8601_timestamp_to_epoch_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_timestamp_to_epoch_unit_tb
// self-checking bench for the timestamp text to Unix seconds converter
// ----------------------------------------------------------------------------
// Timestamp strings are queued one character per entry. A clocked driver
// feeds them to the item channel, and a clocked monitor collects results from
// the result channel. Each accepted character also goes through a parser model
// kept in the bench. On a final character, that model gives the expected
// seconds and valid flag. A short directed set covers the range edges, every
// suffix form, bad lengths and bad characters. Then come random strings:
// mostly well-formed with random fields, plus corrupted, cut, overlong and
// pure noise strings. Both channels stall at random, except for a calm window.
// ----------------------------------------------------------------------------
module iso8601_timestamp_to_epoch_unit_tb;

	localparam int QUIET_LIMIT  = 1000;  // cycles with no transaction at all
	localparam int DRAIN_CYCLES = 64;
	localparam int STIM_CHARS   = 1500;  // directed part plus random strings
	localparam int CALM_FIRST   = 1200;  // cycle window with no idling
	localparam int CALM_LAST    = 2000;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;   // final character of its string
		logic       hold;  // wait for every outstanding result first
	} char_item_t;

	typedef struct packed {
		logic signed [38:0] secs;
		logic               ok;
	} epoch_result_t;

	// dut ports
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	logic [7:0]         character = '0;
	logic               last_char = 1'b0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [38:0] epoch_seconds;
	logic               valid_res;

	// stimulus and scoreboard
	char_item_t    pending[$];
	epoch_result_t epoch_due[$];
	logic [7:0]    text_buf[$];
	char_item_t    next_item;
	epoch_result_t new_due;
	epoch_result_t exp_res;
	int            results_sent = 0;
	int            results_seen = 0;
	int            fail_count = 0;
	int            quiet_cycles = 0;
	int            cycle_no = 0;
	logic          calm;

	// parser model state
	logic [4:0]  pos;
	logic        fmt_ok;
	logic [13:0] yr;
	logic [6:0]  mon, dy, hr, mi, sc, off_hr, off_mi;
	logic        off_neg;
	logic        zulu;

	iso8601_timestamp_to_epoch_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.character    (character),
		.last_char    (last_char),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.epoch_seconds(epoch_seconds),
		.valid_res    (valid_res)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	assign calm = (cycle_no >= CALM_FIRST) && (cycle_no < CALM_LAST);

	// ------------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------------
	function automatic void clear_parse();
		pos = '0;
		fmt_ok = 1'b1;
		yr = '0;
		{mon, dy, hr, mi, sc, off_hr, off_mi} = '0;
		off_neg = 1'b0;
		zulu = 1'b0;
	endfunction

	// takes one character; returns 1 with the expected result on a final one
	function automatic bit parse_step(input logic [7:0] ch, input logic fin,
			output epoch_result_t res);
		logic [4:0] p;
		logic [3:0] dig;
		bit         is_num;
		bit         ok;
		int         len;
		longint     y, m, era, yoe, doy, doe, days, secs, off;

		p = pos;
		is_num = (ch >= iso_ep_pkg::CH_0) && (ch <= iso_ep_pkg::CH_9);
		dig = ch[3:0];
		res = '0;

		// digit slots are everything up to the offset minute except separators
		if (p <= 5'd24 && !(p inside {5'd4, 5'd7, 5'd10, 5'd13, 5'd16,
				iso_ep_pkg::POS_SUFFIX, 5'd22})) begin
			if (!is_num) begin
				fmt_ok = 1'b0;
			end else if (p <= 5'd3) begin
				yr = yr * 14'd10 + dig;
			end else if (p <= 5'd6) begin
				mon = mon * 7'd10 + dig;
			end else if (p <= 5'd9) begin
				dy = dy * 7'd10 + dig;
			end else if (p <= 5'd12) begin
				hr = hr * 7'd10 + dig;
			end else if (p <= 5'd15) begin
				mi = mi * 7'd10 + dig;
			end else if (p <= 5'd18) begin
				sc = sc * 7'd10 + dig;
			end else if (p <= 5'd21) begin
				off_hr = off_hr * 7'd10 + dig;
			end else begin
				off_mi = off_mi * 7'd10 + dig;
			end
		end else begin
			case (p)
				5'd4, 5'd7: begin
					if (ch != iso_ep_pkg::CH_DASH) fmt_ok = 1'b0;
				end
				5'd10: begin
					if (ch != iso_ep_pkg::CH_T) fmt_ok = 1'b0;
				end
				5'd13, 5'd16, 5'd22: begin
					if (ch != iso_ep_pkg::CH_COLON) fmt_ok = 1'b0;
				end
				iso_ep_pkg::POS_SUFFIX: begin
					if (ch == iso_ep_pkg::CH_Z) zulu = 1'b1;
					else if (ch == iso_ep_pkg::CH_DASH) off_neg = 1'b1;
					else if (ch != iso_ep_pkg::CH_PLUS) fmt_ok = 1'b0;
				end
				default: begin
					fmt_ok = 1'b0;
				end
			endcase
		end
		if (pos < iso_ep_pkg::POS_SAT) pos = pos + 5'd1;
		if (!fin) return 0;

		// length decides which suffix is legal
		len = int'(p) + 1;
		ok = fmt_ok;
		if (len == iso_ep_pkg::LEN_ZULU) begin
			ok = ok && zulu;
		end else if (len == iso_ep_pkg::LEN_OFFSET) begin
			ok = ok && !zulu && off_hr <= 7'd23 && off_mi <= 7'd59;
		end else begin
			ok = 0;
		end
		ok = ok && yr >= 14'd1970 && yr <= 14'd9999 && mon >= 7'd1 && mon <= 7'd12
			&& dy >= 7'd1 && dy <= 7'd31 && hr <= 7'd23 && mi <= 7'd59 && sc <= 7'd60;

		if (ok) begin
			// days from civil on a march-based year
			y = yr;
			m = mon;
			if (m <= 2) y = y - 1;
			era = y / 400;
			yoe = y - era * 400;
			doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + dy - 1;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
			days = era * 146097 + doe - 719468;
			secs = days * 86400 + longint'(hr) * 3600 + longint'(mi) * 60 + longint'(sc);
			if (len == iso_ep_pkg::LEN_OFFSET) begin
				off = longint'(off_hr) * 3600 + longint'(off_mi) * 60;
				secs = off_neg ? secs + off : secs - off;
			end
			res.secs = secs[38:0];
			res.ok = 1'b1;
		end
		clear_parse();
		return 1;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------------
	task automatic load_text(input string s);
		text_buf = {};
		for (int i = 0; i < s.len(); i++) text_buf = {text_buf, s[i]};
	endtask

	task automatic load_stamp(input int y, input int mo, input int d, input int h,
			input int mn, input int s, input logic [7:0] sfx, input int oh, input int om);
		string txt;
		txt = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", y, mo, d, h, mn, s);
		if (sfx == iso_ep_pkg::CH_Z) txt = {txt, "Z"};
		else txt = {txt, $sformatf("%c%02d:%02d", sfx, oh, om)};
		load_text(txt);
	endtask

	// moves the text buffer to the pending queue, flagging the final character
	task automatic post_text(input bit hold);
		char_item_t it;
		for (int i = 0; i < text_buf.size(); i++) begin
			it.ch = text_buf[i];
			it.fin = (i == text_buf.size() - 1);
			it.hold = hold && (i == 0);
			pending = {pending, it};
		end
	endtask

	// mostly in range, sometimes anywhere in the digit span
	function automatic int pick(input int lo, input int hi, input int span);
		if ($urandom_range(0, 99) < 90) return $urandom_range(lo, hi);
		return $urandom_range(0, span);
	endfunction

	task automatic load_random_stamp();
		logic [7:0] sfx;
		case ($urandom_range(0, 2))
			0: sfx = iso_ep_pkg::CH_Z;
			1: sfx = iso_ep_pkg::CH_PLUS;
			default: sfx = iso_ep_pkg::CH_DASH;
		endcase
		load_stamp(pick(1970, 9999, 9999), pick(1, 12, 99), pick(1, 31, 99),
			pick(0, 23, 99), pick(0, 59, 99), pick(0, 60, 99), sfx,
			pick(0, 23, 99), pick(0, 59, 99));
	endtask

	task automatic build_stimulus();
		int kind;
		int n;

		// directed: range edges, suffix forms and the rejection cases
		load_stamp(1970, 1, 1, 0, 0, 0, iso_ep_pkg::CH_Z, 0, 0);
		post_text(0);
		load_stamp(9999, 12, 31, 23, 59, 60, iso_ep_pkg::CH_DASH, 23, 59);  // largest value
		post_text(0);
		load_stamp(1970, 1, 1, 0, 0, 0, iso_ep_pkg::CH_PLUS, 23, 59);       // most negative
		post_text(1);
		load_stamp(2024, 2, 31, 12, 30, 45, iso_ep_pkg::CH_Z, 0, 0);        // day rolls over
		post_text(0);
		load_stamp(2000, 3, 1, 0, 0, 0, iso_ep_pkg::CH_DASH, 5, 30);
		post_text(0);
		load_stamp(1969, 12, 31, 23, 59, 59, iso_ep_pkg::CH_Z, 0, 0);       // year too low
		post_text(0);
		load_stamp(2001, 0, 32, 24, 60, 61, iso_ep_pkg::CH_Z, 0, 0);        // fields out of range
		post_text(0);
		load_stamp(2001, 13, 0, 0, 0, 0, iso_ep_pkg::CH_PLUS, 24, 60);      // offset out of range
		post_text(1);
		load_text("2000-01-01T00:00:00");                       // no suffix
		post_text(0);
		load_text("2000-01-01T00:00:00+");                      // short offset
		post_text(0);
		load_text("2000-01-01T00:00:00Z00:00");                 // zulu at full length
		post_text(0);
		load_text("2000/01-01T00:00:00Z");                      // bad separator
		post_text(0);
		load_text("2a00-01-01T00:00:00X");                      // bad digit and suffix
		post_text(0);
		load_text("2000-01-01T00:00:00+01:0000000");            // too long
		post_text(0);
		load_text("Z");                                         // single character
		post_text(0);

		// random part
		while (pending.size() < STIM_CHARS) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				load_random_stamp();
			end else if (kind < 85) begin
				// well-formed shape with one byte replaced or the tail cut
				load_random_stamp();
				if ($urandom_range(0, 1)) begin
					text_buf[$urandom_range(0, text_buf.size() - 1)] =
						8'($urandom_range(0, 255));
				end else begin
					n = $urandom_range(1, text_buf.size() - 1);
					text_buf = text_buf[0:text_buf.size() - 1 - n];
				end
			end else if (kind < 93) begin
				// pure noise of random length
				text_buf = {};
				n = $urandom_range(1, 30);
				repeat (n) text_buf = {text_buf, 8'($urandom_range(0, 255))};
			end else begin
				// stamp prefix running past its legal length
				load_random_stamp();
				n = $urandom_range(1, 6);
				repeat (n) text_buf = {text_buf, 8'($urandom_range(0, 255))};
			end
			post_text($urandom_range(0, 11) == 0);
		end
	endtask

	// ------------------------------------------------------------------------
	// driver: one character per transaction, parser model runs on acceptance
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			character <= '0;
			last_char <= 1'b0;
			clear_parse();
		end else begin
			if (item_valid && item_ready) begin
				if (parse_step(character, last_char, new_due)) begin
					epoch_due = {epoch_due, new_due};
					results_sent = results_sent + 1;
				end
			end
			// the channel is free to load a new character
			if (!item_valid || item_ready) begin
				if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 8)
						&& (!pending[0].hold || results_sent == results_seen)) begin
					next_item = pending.pop_front();
					item_valid <= 1'b1;
					character <= next_item.ch;
					last_char <= next_item.fin;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: compare every result transaction with the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				results_seen <= results_seen + 1;
				if (epoch_due.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result with nothing expected: secs %0d valid %0b",
							$time, epoch_seconds, valid_res);
					fail_count <= fail_count + 1;
				end else begin
					exp_res = epoch_due.pop_front();
					if (exp_res.secs !== epoch_seconds || exp_res.ok !== valid_res) begin
						if (fail_count < 10)
							$display("%0t: mismatch: expected secs %0d valid %0b, got secs %0d valid %0b",
								$time, exp_res.secs, exp_res.ok, epoch_seconds, valid_res);
						fail_count <= fail_count + 1;
					end
				end
			end
			result_ready <= calm || ($urandom_range(0, 99) >= 8);
		end
	end

	// cycles since the last transaction on either channel
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles < QUIET_LIMIT)
			quiet_cycles <= quiet_cycles + 1;
	end

	// ------------------------------------------------------------------------
	// sequence: stimulus, reset, wait for completion or timeout
	// ------------------------------------------------------------------------
	initial begin
		build_stimulus();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while ((pending.size() != 0 || item_valid || results_sent != results_seen)
				&& quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (quiet_cycles >= QUIET_LIMIT)
			$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
		if (epoch_due.size() != 0)
			$display("%0d expected results never arrived", epoch_due.size());
		if (quiet_cycles < QUIET_LIMIT && fail_count == 0 && epoch_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
